/* rtl/deqd_pkg.sv */
// Shared constants for the double-ended queue: request kinds, status codes and default depth.
package deqd_pkg;

    localparam int DEPTH_DEF = 32;

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

/* rtl/deqd_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module deqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/double_ended_queue_with_dump_core.sv */
// Bounded double-ended queue in a ring RAM with front/back push and pop and a full dump.
// Push, or any request answered with full or empty: accepted, result valid the next cycle.
// Pop: the value comes through the RAM's registered read, so the result passes S_READ before S_OUT.
// Dump: each entry passes S_READ and then S_OUT; the next entry is read once the current one is transferred.
// One request at a time: s_tready is high only while the sequencer is idle and no result waits,
// so a new request is not taken before the result of the last one has been transferred.
// Synchronous active-low reset empties the queue; RAM contents are not cleared.
module double_ended_queue_with_dump_core #(
    parameter int DEPTH = deqd_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] item_value
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // last_of_run
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t                            state_reg, state_next;
    logic [IDX_W-1:0]                  front_reg, front_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [CNT_W-1:0]                  dump_off_reg, dump_off_next;
    logic                              is_dump_reg, is_dump_next;
    logic [deqd_pkg::VALUE_W-1:0]      m_tdata_reg, m_tdata_next;
    logic [deqd_pkg::STATUS_W-1:0]     m_tuser_reg, m_tuser_next;
    logic                              m_tlast_reg, m_tlast_next;

    logic [CNT_W-1:0]                  offset;
    logic [SUM_W-1:0]                  pos_sum;
    logic [IDX_W-1:0]                  ring_idx;
    logic [IDX_W-1:0]                  front_inc;
    logic                              is_full;
    logic                              is_empty;
    logic                              wr_en;
    logic                              rd_en;
    logic [deqd_pkg::VALUE_W-1:0]      rd_data;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Shared ring-position unit: front plus an offset, folded back into the ring once.
    always_comb begin
        offset = '0;
        if (state_reg == S_IDLE) begin
            case (s_tuser)
                deqd_pkg::REQ_PUSH_FRONT: offset = CNT_W'(DEPTH - 1);
                deqd_pkg::REQ_PUSH_BACK:  offset = count_reg;
                deqd_pkg::REQ_POP_BACK:   offset = count_reg - CNT_W'(1);
                default:                  offset = '0;
            endcase
        end else begin
            offset = dump_off_reg + CNT_W'(1);
        end
    end

    assign pos_sum   = SUM_W'(front_reg) + SUM_W'(offset);
    assign ring_idx  = (pos_sum >= SUM_W'(DEPTH)) ? IDX_W'(pos_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(pos_sum);
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + IDX_W'(1);

    always_comb begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        dump_off_next = dump_off_reg;
        is_dump_next  = is_dump_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        deqd_pkg::REQ_PUSH_FRONT, deqd_pkg::REQ_PUSH_BACK: begin
                            is_dump_next = 1'b0;
                            m_tlast_next = 1'b1;
                            state_next   = S_OUT;
                            if (is_full) begin
                                m_tuser_next = deqd_pkg::ST_FULL;
                                m_tdata_next = '0;
                            end else begin
                                wr_en        = 1'b1;
                                count_next   = count_reg + CNT_W'(1);
                                m_tuser_next = deqd_pkg::ST_OK;
                                m_tdata_next = s_tdata;
                                if (s_tuser == deqd_pkg::REQ_PUSH_FRONT) begin
                                    front_next = ring_idx;
                                end
                            end
                        end
                        deqd_pkg::REQ_POP_FRONT, deqd_pkg::REQ_POP_BACK,
                        deqd_pkg::REQ_DUMP: begin
                            is_dump_next = (s_tuser == deqd_pkg::REQ_DUMP);
                            if (is_empty) begin
                                m_tuser_next = deqd_pkg::ST_EMPTY;
                                m_tdata_next = '0;
                                m_tlast_next = 1'b1;
                                state_next   = S_OUT;
                            end else begin
                                rd_en         = 1'b1;
                                dump_off_next = '0;
                                state_next    = S_READ;
                                if (s_tuser == deqd_pkg::REQ_POP_FRONT) begin
                                    front_next = front_inc;
                                    count_next = count_reg - CNT_W'(1);
                                end else if (s_tuser == deqd_pkg::REQ_POP_BACK) begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            // Unknown request kinds are consumed without a result.
                        end
                    endcase
                end
            end
            S_READ: begin
                m_tdata_next = rd_data;
                m_tuser_next = deqd_pkg::ST_OK;
                m_tlast_next = is_dump_reg ? ((dump_off_reg + CNT_W'(1)) == count_reg) : 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    if (is_dump_reg && !m_tlast_reg) begin
                        // Fetch the next entry of the dump through the ring unit.
                        rd_en         = 1'b1;
                        dump_off_next = dump_off_reg + CNT_W'(1);
                        state_next    = S_READ;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            dump_off_reg <= '0;
            is_dump_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            front_reg    <= front_next;
            count_reg    <= count_next;
            dump_off_reg <= dump_off_next;
            is_dump_reg  <= is_dump_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    deqd_ram #(
        .WIDTH (deqd_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (ring_idx),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr ((s_tuser == deqd_pkg::REQ_POP_FRONT && state_reg == S_IDLE)
                  ? front_reg : ring_idx),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // The fill level never exceeds the ring size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // Only one request is in flight: no new transfer is taken while a result waits.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // A push on a full queue leaves the fill level alone.
    a_full_push_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && is_full &&
         (s_tuser == deqd_pkg::REQ_PUSH_FRONT || s_tuser == deqd_pkg::REQ_PUSH_BACK))
        |=> $stable(count_reg) && $stable(front_reg))
        else $error("push on full queue changed the state");

    // The transfer marked last returns the sequencer to idle.
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("sequencer did not return to idle after the last result");

    // A dump result is marked last exactly when it is the final stored entry.
    a_dump_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && is_dump_reg && m_tuser == deqd_pkg::ST_OK)
        |-> (m_tlast == ((dump_off_reg + CNT_W'(1)) == count_reg)))
        else $error("dump last marker out of place");

endmodule
